// ===== hw/rtl/ptt_pkg.sv =====
`default_nettype none

package ptt_pkg;

  // table sizing
  localparam int MAX_TIMERS = 16;
  localparam int ID_BITS    = 16;
  localparam int TIME_BITS  = 32;

  // derived widths
  localparam int IDX_BITS = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_BITS = $clog2(MAX_TIMERS + 1);
  localparam int REM_BITS = TIME_BITS + 2;

  // fixed field widths of the channels
  localparam int FLD_PERIOD_BITS = 32;
  localparam int FLD_ID_BITS     = 16;
  localparam int FLD_CNT_BITS    = 5;

  // request codes
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_FLUSH  = 2'd3
  } action_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIRED  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  // shared subtract unit request and response
  typedef struct packed {
    logic signed [REM_BITS-1:0] a;
    logic signed [REM_BITS-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic signed [REM_BITS-1:0] diff;
    logic                       neg;
    logic                       le_zero;
  } alu_rsp_t;

  // one result from the sequencer to the output register
  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    status_t                 status;
    logic [FLD_ID_BITS-1:0]  result_id;
    logic [FLD_CNT_BITS-1:0] active_count;
    logic                    last;
  } emit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptt_in_if.sv =====
`default_nettype none

interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] period_ms;
  logic        single_shot;
  logic [15:0] timer_id;
  logic [31:0] elapsed_ms;

  modport source (
    output valid, action, period_ms, single_shot, timer_id, elapsed_ms,
    input  ready
  );

  modport sink (
    input  valid, action, period_ms, single_shot, timer_id, elapsed_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/ptt_out_if.sv =====
`default_nettype none

interface ptt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [15:0] result_id;
  logic [4:0]  active_count;
  logic        last;

  modport source (
    output valid, kind, status, result_id, active_count, last,
    input  ready
  );

  modport sink (
    input  valid, kind, status, result_id, active_count, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/ptt_alu.sv =====
`default_nettype none

module ptt_alu
  import ptt_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic signed [REM_BITS-1:0] diff;

  // one signed subtract serves both the tick decrement and the min compare
  assign diff        = req.a - req.b;
  assign rsp.diff    = diff;
  assign rsp.neg     = diff[REM_BITS-1];
  assign rsp.le_zero = diff[REM_BITS-1] || (diff == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/ptt_seq.sv =====
`default_nettype none

module ptt_seq
  import ptt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  ptt_in_if.sink   in_ch,
  output alu_req_t alu_req,
  input  alu_rsp_t alu_rsp,
  output emit_t    emit,
  input  logic     emit_ok
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REMOVE,
    ST_TICK_SUB,
    ST_TICK_MIN,
    ST_TICK_FIRE,
    ST_FLUSH,
    ST_DONE
  } state_t;

  state_t                     state_r;
  logic [IDX_BITS-1:0]        idx_r;
  logic [IDX_BITS-1:0]        best_r;
  logic signed [REM_BITS-1:0] best_rem_r;
  logic                       found_r;
  logic [TIME_BITS-1:0]       period_r;
  logic                       single_r;
  logic [ID_BITS-1:0]         tid_r;
  logic [TIME_BITS-1:0]       elapsed_r;
  logic [CNT_BITS-1:0]        count_r;
  logic [ID_BITS-1:0]         next_id_r;
  logic [MAX_TIMERS-1:0]      valid_r;
  logic [MAX_TIMERS-1:0]      pend_r;

  // slot storage
  logic [ID_BITS-1:0]         slot_id_r     [MAX_TIMERS];
  logic [TIME_BITS-1:0]       slot_period_r [MAX_TIMERS];
  logic signed [REM_BITS-1:0] slot_rem_r    [MAX_TIMERS];
  logic                       slot_single_r [MAX_TIMERS];

  logic                idx_last;
  logic                free_found;
  logic [IDX_BITS-1:0] free_idx;
  logic [ID_BITS-1:0]  id_inc;
  logic [ID_BITS-1:0]  new_id;
  logic                rm_hit;
  logic                take;
  logic [CNT_BITS-1:0] cnt_inc;
  logic [CNT_BITS-1:0] cnt_dec;
  logic [CNT_BITS-1:0] fire_count;

  assign idx_last = (idx_r == IDX_BITS'(MAX_TIMERS - 1));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_BITS'(i);
      end
    end
  end

  // running id, zero skipped
  assign id_inc = next_id_r + 1'b1;
  assign new_id = (id_inc == '0) ? ID_BITS'(1) : id_inc;

  assign rm_hit = valid_r[idx_r] && (slot_id_r[idx_r] == tid_r);

  // shared unit operands: decrement during tick walk, compare during min walk
  assign alu_req.a = slot_rem_r[idx_r];
  assign alu_req.b = (state_r == ST_TICK_SUB) ? $signed({2'b00, elapsed_r}) : best_rem_r;

  assign take = pend_r[idx_r] && (!found_r || alu_rsp.neg);

  assign cnt_inc    = count_r + 1'b1;
  assign cnt_dec    = count_r - 1'b1;
  assign fire_count = slot_single_r[idx_r] ? cnt_dec : count_r;

  assign in_ch.ready = (state_r == ST_IDLE);

  // result built from the current step
  always_comb begin
    emit = '0;
    unique case (state_r)
      ST_ADD: begin
        emit.valid = 1'b1;
        emit.kind  = KIND_ADD;
        emit.last  = 1'b1;
        if (free_found) begin
          emit.status       = STAT_OK;
          emit.result_id    = FLD_ID_BITS'(new_id);
          emit.active_count = FLD_CNT_BITS'(cnt_inc);
        end else begin
          emit.status       = STAT_FULL;
          emit.active_count = FLD_CNT_BITS'(count_r);
        end
      end
      ST_REMOVE: begin
        emit.valid = rm_hit || idx_last;
        emit.kind  = KIND_REMOVE;
        emit.last  = 1'b1;
        if (rm_hit) begin
          emit.status       = STAT_OK;
          emit.result_id    = FLD_ID_BITS'(tid_r);
          emit.active_count = FLD_CNT_BITS'(cnt_dec);
        end else begin
          emit.status       = STAT_NOT_FOUND;
          emit.active_count = FLD_CNT_BITS'(count_r);
        end
      end
      ST_TICK_FIRE: begin
        emit.valid        = 1'b1;
        emit.kind         = KIND_FIRED;
        emit.status       = STAT_OK;
        emit.result_id    = FLD_ID_BITS'(slot_id_r[idx_r]);
        emit.active_count = FLD_CNT_BITS'(fire_count);
      end
      ST_FLUSH: begin
        emit.valid        = valid_r[idx_r];
        emit.kind         = KIND_FIRED;
        emit.status       = STAT_OK;
        emit.result_id    = FLD_ID_BITS'(slot_id_r[idx_r]);
        emit.active_count = FLD_CNT_BITS'(cnt_dec);
      end
      ST_DONE: begin
        emit.valid        = 1'b1;
        emit.kind         = KIND_DONE;
        emit.status       = STAT_OK;
        emit.active_count = FLD_CNT_BITS'(count_r);
        emit.last         = 1'b1;
      end
      default: begin
        emit = '0;
      end
    endcase
  end

  // sequencer and slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      found_r   <= 1'b0;
      count_r   <= '0;
      next_id_r <= '0;
      valid_r   <= '0;
      pend_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            period_r  <= TIME_BITS'(in_ch.period_ms);
            single_r  <= in_ch.single_shot;
            tid_r     <= ID_BITS'(in_ch.timer_id);
            elapsed_r <= TIME_BITS'(in_ch.elapsed_ms);
            idx_r     <= '0;
            unique case (in_ch.action)
              ACT_ADD:    state_r <= ST_ADD;
              ACT_REMOVE: state_r <= ST_REMOVE;
              ACT_TICK:   state_r <= ST_TICK_SUB;
              ACT_FLUSH:  state_r <= ST_FLUSH;
            endcase
          end
        end

        ST_ADD: begin
          if (emit_ok) begin
            if (free_found) begin
              valid_r[free_idx]       <= 1'b1;
              slot_id_r[free_idx]     <= new_id;
              slot_period_r[free_idx] <= period_r;
              slot_rem_r[free_idx]    <= $signed({2'b00, period_r});
              slot_single_r[free_idx] <= single_r;
              count_r                 <= cnt_inc;
              next_id_r               <= new_id;
            end
            state_r <= ST_IDLE;
          end
        end

        // walk slots for the lowest match
        ST_REMOVE: begin
          if (rm_hit) begin
            if (emit_ok) begin
              valid_r[idx_r] <= 1'b0;
              count_r        <= cnt_dec;
              state_r        <= ST_IDLE;
            end
          end else if (idx_last) begin
            if (emit_ok) begin
              state_r <= ST_IDLE;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end

        // subtract elapsed time from each active slot, mark the expired ones
        ST_TICK_SUB: begin
          if (valid_r[idx_r]) begin
            slot_rem_r[idx_r] <= alu_rsp.diff;
            pend_r[idx_r]     <= alu_rsp.le_zero;
          end else begin
            pend_r[idx_r] <= 1'b0;
          end
          if (idx_last) begin
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= ST_TICK_MIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end

        // one pass finds the pending slot with least remaining time
        ST_TICK_MIN: begin
          if (take) begin
            best_r     <= idx_r;
            best_rem_r <= slot_rem_r[idx_r];
            found_r    <= 1'b1;
          end
          if (idx_last) begin
            if (take || found_r) begin
              idx_r   <= take ? idx_r : best_r;
              state_r <= ST_TICK_FIRE;
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end

        // fire the chosen slot, reload or free it
        ST_TICK_FIRE: begin
          if (emit_ok) begin
            pend_r[idx_r] <= 1'b0;
            if (slot_single_r[idx_r]) begin
              valid_r[idx_r] <= 1'b0;
              count_r        <= cnt_dec;
            end else begin
              slot_rem_r[idx_r] <= $signed({2'b00, slot_period_r[idx_r]});
            end
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= ST_TICK_MIN;
          end
        end

        // fire and free every active slot in slot order
        ST_FLUSH: begin
          if (!valid_r[idx_r] || emit_ok) begin
            if (valid_r[idx_r]) begin
              valid_r[idx_r] <= 1'b0;
              count_r        <= cnt_dec;
            end
            if (idx_last) begin
              state_r <= ST_DONE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end

        ST_DONE: begin
          if (emit_ok) begin
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_timer_table_unit.sv =====
// Table of up to MAX_TIMERS millisecond timers driven by add, remove, tick and
// flush requests; each request yields one or more result transactions, the
// final one flagged by last. A small sequencer walks the slots one per cycle,
// pausing while a result waits to be taken, and shares one signed subtractor
// for both the tick decrement and the least-remaining-time compare.
// The input is not ready while a request is in progress; a result register
// lets the next request be accepted while the last result still waits, and
// any stall on the result side holds the sequencer.
`default_nettype none

module periodic_timer_table_unit
  import ptt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  ptt_in_if.sink     in_ch,
  ptt_out_if.source  out_ch
);

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  emit_t    emit;
  logic     emit_ok;

  logic                    out_valid_r;
  kind_t                   out_kind_r;
  status_t                 out_status_r;
  logic [FLD_ID_BITS-1:0]  out_id_r;
  logic [FLD_CNT_BITS-1:0] out_count_r;
  logic                    out_last_r;

  ptt_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp),
    .emit    (emit),
    .emit_ok (emit_ok)
  );

  ptt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // result register, loads when empty or being drained
  assign emit_ok = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid && emit_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && emit_ok) begin
      out_kind_r   <= emit.kind;
      out_status_r <= emit.status;
      out_id_r     <= emit.result_id;
      out_count_r  <= emit.active_count;
      out_last_r   <= emit.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_id    = out_id_r;
  assign out_ch.active_count = out_count_r;
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire

// ===== test/periodic_timer_table_unit_test.sv =====
`timescale 1ns / 100ps

module periodic_timer_table_unit_test;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_ITEMS = 230;
  localparam int ERR_PRINTS = 10;

  // one result transaction as the block should report it
  typedef struct {
    kind_t                   kind;
    status_t                 status;
    logic [FLD_ID_BITS-1:0]  result_id;
    logic [FLD_CNT_BITS-1:0] active_count;
    logic                    last;
  } timer_result_t;

  // timer table predictor and result checker
  class timer_table_scoreboard;
    bit                         slot_live [MAX_TIMERS];
    logic [ID_BITS-1:0]         slot_tag [MAX_TIMERS];
    logic [TIME_BITS-1:0]       slot_reload [MAX_TIMERS];
    logic signed [REM_BITS-1:0] slot_left [MAX_TIMERS];
    bit                         slot_once [MAX_TIMERS];
    logic [ID_BITS-1:0]         last_id;
    timer_result_t              pending_results[$];
    int                         error_count;

    function new();
      for (int i = 0; i < MAX_TIMERS; i++) begin
        slot_live[i] = 1'b0;
        slot_tag[i] = '0;
        slot_reload[i] = '0;
        slot_left[i] = '0;
        slot_once[i] = 1'b0;
      end
      last_id = '0;
      error_count = 0;
    endfunction

    function int active_total();
      int n;
      n = 0;
      for (int i = 0; i < MAX_TIMERS; i++)
        if (slot_live[i]) n++;
      return n;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // id of a random running timer, or any id when the table is empty
    function logic [15:0] pick_live_id();
      logic [15:0] ids[$];
      for (int i = 0; i < MAX_TIMERS; i++)
        if (slot_live[i]) ids.push_back(16'(slot_tag[i]));
      if (ids.size() == 0) return 16'($urandom);
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function void push_result(kind_t k, status_t s, logic [ID_BITS-1:0] id, logic fin);
      timer_result_t r;
      r.kind = k;
      r.status = s;
      r.result_id = FLD_ID_BITS'(id);
      r.active_count = FLD_CNT_BITS'(active_total());
      r.last = fin;
      pending_results.push_back(r);
    endfunction

    // work out every result that one accepted request causes
    function void note_request(action_t act, logic [31:0] period, logic single,
                               logic [15:0] tid, logic [31:0] elapsed);
      int                 slot;
      int                 best;
      bit                 due [MAX_TIMERS];
      logic [ID_BITS-1:0] id;
      case (act)
        ACT_ADD: begin
          slot = -1;
          for (int i = MAX_TIMERS - 1; i >= 0; i--)
            if (!slot_live[i]) slot = i;
          if (slot < 0) begin
            push_result(KIND_ADD, STAT_FULL, '0, 1'b1);
          end else begin
            id = last_id + 1'b1;
            if (id == '0) id = ID_BITS'(1);
            last_id = id;
            slot_live[slot] = 1'b1;
            slot_tag[slot] = id;
            slot_reload[slot] = period[TIME_BITS-1:0];
            slot_left[slot] = $signed({2'b00, period[TIME_BITS-1:0]});
            slot_once[slot] = single;
            push_result(KIND_ADD, STAT_OK, id, 1'b1);
          end
        end
        ACT_REMOVE: begin
          id = tid[ID_BITS-1:0];
          slot = -1;
          for (int i = MAX_TIMERS - 1; i >= 0; i--)
            if (slot_live[i] && slot_tag[i] == id) slot = i;
          if (slot < 0) begin
            push_result(KIND_REMOVE, STAT_NOT_FOUND, '0, 1'b1);
          end else begin
            slot_live[slot] = 1'b0;
            push_result(KIND_REMOVE, STAT_OK, id, 1'b1);
          end
        end
        ACT_TICK: begin
          // age every timer, then fire the due ones by least time left
          for (int i = 0; i < MAX_TIMERS; i++) begin
            due[i] = 1'b0;
            if (slot_live[i]) begin
              slot_left[i] = slot_left[i] - $signed({2'b00, elapsed[TIME_BITS-1:0]});
              due[i] = (slot_left[i] <= 0);
            end
          end
          forever begin
            best = -1;
            for (int i = 0; i < MAX_TIMERS; i++)
              if (due[i] && (best < 0 || slot_left[i] < slot_left[best])) best = i;
            if (best < 0) break;
            due[best] = 1'b0;
            if (slot_once[best]) slot_live[best] = 1'b0;
            else slot_left[best] = $signed({2'b00, slot_reload[best]});
            push_result(KIND_FIRED, STAT_OK, slot_tag[best], 1'b0);
          end
          push_result(KIND_DONE, STAT_OK, '0, 1'b1);
        end
        default: begin
          for (int i = 0; i < MAX_TIMERS; i++) begin
            if (slot_live[i]) begin
              slot_live[i] = 1'b0;
              push_result(KIND_FIRED, STAT_OK, slot_tag[i], 1'b0);
            end
          end
          push_result(KIND_DONE, STAT_OK, '0, 1'b1);
        end
      endcase
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [1:0] kind, logic [1:0] status, logic [15:0] rid,
                               logic [4:0] count, logic fin);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= ERR_PRINTS)
          $display("unexpected result: kind %0d status %0d id %0d count %0d last %0d",
                   kind, status, rid, count, fin);
        return;
      end
      want = pending_results.pop_front();
      if (want.kind !== kind || want.status !== status || want.result_id !== rid ||
          want.active_count !== count || want.last !== fin) begin
        error_count++;
        if (error_count <= ERR_PRINTS) begin
          $write("result mismatch (exp/act): kind %0d/%0d status %0d/%0d id %0d/%0d",
                 want.kind, kind, want.status, status, want.result_id, rid);
          $display(" count %0d/%0d last %0d/%0d",
                   want.active_count, count, want.last, fin);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   fast_mode;
  int   burst_left;
  timer_table_scoreboard sb;

  ptt_in_if  in_bus ();
  ptt_out_if out_bus ();

  periodic_timer_table_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // result side: check each transaction, stall on a changing pattern
  initial begin
    int rx_mode;
    int rx_left;
    rx_mode = 0;
    rx_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.kind, out_bus.status, out_bus.result_id,
                        out_bus.active_count, out_bus.last);
      if (fast_mode) begin
        out_bus.ready <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(10, 60);
        end
        rx_left--;
        case (rx_mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 1) == 1);
          2: out_bus.ready <= (rx_left % 4 != 0);
          default: out_bus.ready <= (rx_left % 7 < 2);
        endcase
      end
    end
  end

  // drive one request and wait until it is accepted; bursts with random gaps
  task automatic send_request(action_t act, logic [31:0] period, logic single,
                              logic [15:0] tid, logic [31:0] elapsed);
    int gap;
    if (!fast_mode && burst_left == 0) begin
      in_bus.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.period_ms <= period;
    in_bus.single_shot <= single;
    in_bus.timer_id <= tid;
    in_bus.elapsed_ms <= elapsed;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_request(act, period, single, tid, elapsed);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic add_timer(logic [31:0] period, logic single);
    send_request(ACT_ADD, period, single, 16'($urandom), $urandom);
  endtask

  task automatic remove_timer(logic [15:0] tid);
    send_request(ACT_REMOVE, $urandom, 1'($urandom), tid, $urandom);
  endtask

  task automatic tick_table(logic [31:0] elapsed);
    send_request(ACT_TICK, $urandom, 1'($urandom), 16'($urandom), elapsed);
  endtask

  task automatic flush_table();
    send_request(ACT_FLUSH, $urandom, 1'($urandom), 16'($urandom), $urandom);
  endtask

  // mostly short periods so ticks fire often, some ties and extremes
  task automatic random_add();
    int          pick;
    logic [31:0] period;
    pick = $urandom_range(0, 19);
    if (pick < 11) period = $urandom_range(0, 40);
    else if (pick < 14) period = 32'd20;
    else if (pick < 16) period = 32'd0;
    else period = $urandom;
    add_timer(period, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_remove();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 15) remove_timer(sb.pick_live_id());
    else if (pick < 18) remove_timer(16'($urandom));
    else if (pick < 19) remove_timer(16'd0);
    else remove_timer(16'(sb.last_id + 1'b1));
  endtask

  task automatic random_tick();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) tick_table($urandom_range(0, 30));
    else if (pick < 17) tick_table(32'd0);
    else tick_table($urandom);
  endtask

  // stimulus
  initial begin
    int sel;
    sb = new();
    fast_mode = 1'b0;
    burst_left = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_ADD;
    in_bus.period_ms = '0;
    in_bus.single_shot = 1'b0;
    in_bus.timer_id = '0;
    in_bus.elapsed_ms = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: tick, flush and an unknown id
    tick_table(32'd0);
    flush_table();
    remove_timer(16'd0);

    // zero period, widest period, equal times, then ticks at both extremes
    add_timer(32'd0, 1'b0);
    add_timer(32'hFFFF_FFFF, 1'b1);
    add_timer(32'd5, 1'b1);
    add_timer(32'd5, 1'b0);
    add_timer(32'd3, 1'b0);
    tick_table(32'd0);
    tick_table(32'hFFFF_FFFF);
    remove_timer(16'd1);

    // fill the table, one add past full, then flush it all
    while (sb.active_total() < MAX_TIMERS)
      add_timer($urandom_range(0, 50), 1'($urandom_range(0, 1)));
    add_timer(32'd9, 1'b0);
    flush_table();

    // random mix of requests
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 36) random_add();
      else if (sel < 60) random_remove();
      else if (sel < 97) random_tick();
      else flush_table();
    end

    // final flush with the result side always ready
    fast_mode = 1'b1;
    flush_table();
    fast_mode = 1'b0;
    in_bus.valid <= 1'b0;

    // drain outstanding results, then let the block settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
